// ===== src/mipsalu_pkg.sv =====
package mipsalu_pkg;

  localparam int unsigned ModeW = 6;
  localparam int unsigned DataW = 64;
  localparam int unsigned QueueDepthDef = 2;
  localparam logic [4:0] Mask5 = 5'h1f;

  typedef enum logic [ModeW-1:0] {
    OpAdd = 6'd0, OpSub = 6'd1, OpDadd = 6'd2, OpDsub = 6'd3,
    OpAnd = 6'd4, OpOr = 6'd5, OpXor = 6'd6, OpNor = 6'd7,
    OpSlt = 6'd8, OpSltu = 6'd9, OpSll = 6'd10, OpSrl = 6'd11,
    OpSra = 6'd12, OpSllv = 6'd13, OpSrlv = 6'd14, OpSrav = 6'd15,
    OpDsll = 6'd16, OpDsrl = 6'd17, OpDsra = 6'd18, OpDsllv = 6'd19,
    OpDsrlv = 6'd20, OpDsrav = 6'd21, OpMult = 6'd22, OpMultu = 6'd23,
    OpDiv = 6'd24, OpDivu = 6'd25, OpDmult = 6'd26, OpDmultu = 6'd27,
    OpDdiv = 6'd28, OpDdivu = 6'd29, OpMfhi = 6'd30, OpMflo = 6'd31,
    OpMthi = 6'd32, OpMtlo = 6'd33
  } op_e;

  typedef enum logic [1:0] {
    KindAlu = 2'd0,
    KindMul = 2'd1,
    KindDiv = 2'd2,
    KindHilo = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [ModeW-1:0]  mode;
    logic [DataW-1:0]  a;
    logic [DataW-1:0]  b;
    logic [DataW-1:0]  res;
    logic              we;
  } cmd_t;

  function automatic logic [DataW-1:0] sx32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

endpackage

// ===== src/mipsalu_front.sv =====
module mipsalu_front import mipsalu_pkg::*; (
  input  logic [ModeW-1:0] mode_i,
  input  logic [DataW-1:0] a_i,
  input  logic [DataW-1:0] b_i,
  input  logic [5:0]       sa_i,
  output cmd_t             cmd_o
);

  logic [31:0] a32, b32;
  logic [4:0]  s5;
  logic [5:0]  s6;
  logic [DataW-1:0] res;
  kind_e kind;
  logic we;

  assign a32 = a_i[31:0];
  assign b32 = b_i[31:0];

  always_comb begin
    res  = '0;
    we   = 1'b1;
    kind = KindAlu;
    s5   = sa_i[4:0] & Mask5;
    s6   = sa_i;
    if (mode_i inside {OpSllv, OpSrlv, OpSrav}) s5 = a_i[4:0];
    if (mode_i inside {OpDsllv, OpDsrlv, OpDsrav}) s6 = a_i[5:0];
    case (mode_i)
      OpAdd:  res = sx32(a32 + b32);
      OpSub:  res = sx32(a32 - b32);
      OpDadd: res = a_i + b_i;
      OpDsub: res = a_i - b_i;
      OpAnd:  res = a_i & b_i;
      OpOr:   res = a_i | b_i;
      OpXor:  res = a_i ^ b_i;
      OpNor:  res = ~(a_i | b_i);
      OpSlt:  res = {63'd0, $signed(a_i) < $signed(b_i)};
      OpSltu: res = {63'd0, a_i < b_i};
      OpSll, OpSllv: res = sx32(b32 << s5);
      OpSrl, OpSrlv: res = sx32(b32 >> s5);
      OpSra, OpSrav: res = sx32(32'($signed(b32) >>> s5));
      OpDsll, OpDsllv: res = b_i << s6;
      OpDsrl, OpDsrlv: res = b_i >> s6;
      OpDsra, OpDsrav: res = 64'($signed(b_i) >>> s6);
      OpMult, OpMultu, OpDmult, OpDmultu: begin
        kind = KindMul;
        we = 1'b0;
      end
      OpDiv, OpDivu, OpDdiv, OpDdivu: begin
        kind = KindDiv;
        we = 1'b0;
      end
      OpMfhi, OpMflo: kind = KindHilo;
      OpMthi, OpMtlo: begin
        kind = KindHilo;
        we = 1'b0;
      end
      default: we = 1'b0;
    endcase
  end

  assign cmd_o = '{kind: kind, mode: mode_i, a: a_i, b: b_i, res: res, we: we};

endmodule

// ===== src/mipsalu_queue.sv =====
module mipsalu_queue import mipsalu_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  cmd_t in_cmd_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t out_cmd_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;
  logic push, pop;

  assign in_ready_o  = cnt_q != (PtrW+1)'(Depth);
  assign out_valid_o = cnt_q != '0;
  assign out_cmd_o   = mem_q[rd_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == PtrW'(Depth-1)) ? '0 : wr_q + 1'b1;
      if (pop) rd_q <= (rd_q == PtrW'(Depth-1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

endmodule

// ===== src/mipsalu_back.sv =====
module mipsalu_back import mipsalu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  output logic             cmd_ready_o,
  input  cmd_t             cmd_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [DataW-1:0] result_o,
  output logic             we_o
);

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StMul  = 5'b00010,
    StDiv  = 5'b00100,
    StFix  = 5'b01000,
    StOut  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [DataW-1:0] hi_q, lo_q;
  logic [DataW-1:0] res_q;
  logic             we_q;
  logic [ModeW-1:0] mode_q;
  logic [DataW-1:0] ma_q, mb_q;
  logic [127:0]     acc_q;
  logic [1:0]       pp_q;
  logic [DataW-1:0] rem_q, quo_q, dvs_q;
  logic [6:0]       cnt_q;
  logic             nq_q, nr_q, w32_q;

  logic is32, sgn;
  logic [DataW-1:0] ua, ub, ea, eb;
  logic [DataW:0] trial;
  logic [63:0] pp;
  logic [127:0] ppw;
  logic [DataW:0] rem_sh;
  logic [31:0] mx, my;
  logic [63:0] prod32;

  assign cmd_ready_o = state_q == StIdle && !out_valid_o;
  assign result_o = res_q;
  assign we_o = we_q;

  always_comb begin
    is32 = cmd_i.mode inside {OpMult, OpMultu, OpDiv, OpDivu};
    sgn  = cmd_i.mode inside {OpMult, OpDiv, OpDmult, OpDdiv};
    ea = is32 ? (sgn ? sx32(cmd_i.a[31:0]) : {32'd0, cmd_i.a[31:0]}) : cmd_i.a;
    eb = is32 ? (sgn ? sx32(cmd_i.b[31:0]) : {32'd0, cmd_i.b[31:0]}) : cmd_i.b;
    ua = (sgn && ea[63]) ? 64'd0 - ea : ea;
    ub = (sgn && eb[63]) ? 64'd0 - eb : eb;
  end

  always_comb begin
    mx = pp_q[0] ? ma_q[63:32] : ma_q[31:0];
    my = pp_q[1] ? mb_q[63:32] : mb_q[31:0];
    pp = mx * my;
    ppw = 128'(pp) << {pp_q[1] ^ pp_q[0] ? 7'd32 : (pp_q == 2'd3 ? 7'd64 : 7'd0)};
    rem_sh = {rem_q, quo_q[63]};
    trial = rem_sh - {1'b0, dvs_q};
    prod32 = (nq_q && mode_q == OpMult) ? 64'd0 - acc_q[63:0] : acc_q[63:0];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (cmd_valid_i && cmd_ready_o) begin
        case (cmd_i.kind)
          KindMul: state_d = StMul;
          KindDiv: state_d = (is32 ? cmd_i.b[31:0] == '0 : cmd_i.b == '0) ? StOut : StDiv;
          default: state_d = StOut;
        endcase
      end
      StMul: if (pp_q == 2'd3) state_d = StFix;
      StDiv: if (cnt_q == 7'd1) state_d = StFix;
      StFix: state_d = StOut;
      StOut: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      out_valid_o <= 1'b0;
      hi_q <= '0;
      lo_q <= '0;
    end else begin
      state_q <= state_d;
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      if (state_q == StOut) out_valid_o <= 1'b1;
      if (state_q == StIdle && cmd_valid_i && cmd_ready_o) begin
        case (cmd_i.mode)
          OpMthi: hi_q <= cmd_i.a;
          OpMtlo: lo_q <= cmd_i.a;
          default: ;
        endcase
      end
      if (state_q == StFix) begin
        if (w32_q) begin
          if (mode_q inside {OpMult, OpMultu}) begin
            lo_q <= sx32(prod32[31:0]);
            hi_q <= sx32(prod32[63:32]);
          end else begin
            lo_q <= sx32(nq_q ? 32'd0 - quo_q[31:0] : quo_q[31:0]);
            hi_q <= sx32(nr_q ? 32'd0 - rem_q[31:0] : rem_q[31:0]);
          end
        end else if (mode_q inside {OpDmult, OpDmultu}) begin
          lo_q <= acc_q[63:0];
          hi_q <= acc_q[127:64] - ((mode_q == OpDmult && ma_q[63]) ? mb_q : 64'd0)
                  - ((mode_q == OpDmult && mb_q[63]) ? ma_q : 64'd0);
        end else begin
          lo_q <= nq_q ? 64'd0 - quo_q : quo_q;
          hi_q <= nr_q ? 64'd0 - rem_q : rem_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: if (cmd_valid_i && cmd_ready_o) begin
        mode_q <= cmd_i.mode;
        w32_q <= is32;
        we_q <= cmd_i.we;
        res_q <= cmd_i.res;
        if (cmd_i.mode == OpMfhi) res_q <= hi_q;
        if (cmd_i.mode == OpMflo) res_q <= lo_q;
        if (cmd_i.kind == KindMul) begin
          ma_q <= is32 ? {32'd0, cmd_i.a[31:0]} : cmd_i.a;
          mb_q <= is32 ? {32'd0, cmd_i.b[31:0]} : cmd_i.b;
          if (is32 && sgn) begin
            ma_q <= {32'd0, ua[31:0]};
            mb_q <= {32'd0, ub[31:0]};
          end
          nq_q <= is32 && sgn && (cmd_i.a[31] ^ cmd_i.b[31]);
        end else begin
          nq_q <= sgn && (ea[63] ^ eb[63]);
        end
        nr_q <= sgn && ea[63];
        acc_q <= '0;
        pp_q <= '0;
        rem_q <= '0;
        quo_q <= is32 ? {ua[31:0], 32'd0} : ua;
        dvs_q <= ub;
        cnt_q <= is32 ? 7'd32 : 7'd64;
      end
      StMul: begin
        acc_q <= acc_q + ppw;
        pp_q <= pp_q + 2'd1;
      end
      StDiv: begin
        if (!trial[DataW]) begin
          rem_q <= trial[DataW-1:0];
          quo_q <= {quo_q[62:0], 1'b1};
        end else begin
          rem_q <= rem_sh[DataW-1:0];
          quo_q <= {quo_q[62:0], 1'b0};
        end
        cnt_q <= cnt_q - 7'd1;
      end
      default: ;
    endcase
  end

endmodule

// ===== src/mips64_integer_alu_muldiv.sv =====
// MIPS III integer ALU with HI/LO multiply/divide.
// Input channel s_axis: tdata carries operand_a, operand_b, shift_amount; tuser carries mode.
// Output channel m_axis: tdata carries result; tuser carries write_enable.
// One word in gives exactly one word out, in order.
// A front decoder evaluates ALU ops and classifies the word; a QueueDepth-entry queue
// (two by default) feeds the back unit, which owns HI/LO and the multiply/divide sequencer.
// With an idle back unit, ALU/HI/LO ops go straight to the back unit's output
// state; multiply forms four 32x32 partial products, then a fix-up state; divide
// (32-bit or 64-bit) forms one quotient bit per cycle, then the fix-up state;
// zero-divisor divides go straight to the output state.
// Back unit holds one word at a time and takes the next one the cycle after its
// result is taken, so it cannot accept a new word while a result is pending.
// Reset clears HI, LO, the queue and the output valid.
// A stalled receiver holds the result word; the queue keeps accepting until full.
module mips64_integer_alu_muldiv import mipsalu_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [135:0] s_axis_tdata,  // operand_a, operand_b, shift_amount, zero pad
  input  logic [5:0]   s_axis_tuser,  // mode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,  // result
  output logic         m_axis_tuser   // write_enable
);

  cmd_t cmd, qcmd;
  logic qvalid, qready;
  logic [1:0] pad;

  assign pad = s_axis_tdata[135:134];

  mipsalu_front u_front (
    .mode_i (s_axis_tuser),
    .a_i    (s_axis_tdata[63:0]),
    .b_i    (s_axis_tdata[127:64]),
    .sa_i   (s_axis_tdata[133:128] | {4'd0, pad & 2'b00}),
    .cmd_o  (cmd)
  );

  mipsalu_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni,
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cmd_i    (cmd),
    .out_valid_o (qvalid),
    .out_ready_i (qready),
    .out_cmd_o   (qcmd)
  );

  mipsalu_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i (qvalid),
    .cmd_ready_o (qready),
    .cmd_i       (qcmd),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .result_o    (m_axis_tdata),
    .we_o        (m_axis_tuser)
  );

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result lost under stall");
  a_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !qready)
    else $error("back took word while result pending");
  a_nowe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("nonzero result without write enable");

endmodule
